// ----- rtl/tsmd_pkg.sv -----
// Package with the shared constants, codes and types of the Morse decoder.
package tsmd_pkg;

  localparam int unsigned MAX_MARKS   = 8;
  localparam int unsigned RUN_WIDTH   = 16;
  localparam int unsigned CFG_WIDTH   = 16;
  localparam int unsigned CODE_W      = MAX_MARKS + 1;
  localparam int unsigned TABLE_DEPTH = 1 << CODE_W;
  localparam int unsigned MARK_CNT_W  = $clog2(MAX_MARKS + 1);
  localparam int unsigned CMP_W       = (RUN_WIDTH > CFG_WIDTH) ? RUN_WIDTH : CFG_WIDTH;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_NONE  = 8'd0;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SIGNAL = 2'd1,
    OP_END    = 2'd2
  } tsmd_op_e;

  typedef enum logic [1:0] {
    CFG_DASH_LENGTH = 2'd0,
    CFG_SYMBOL_GAP  = 2'd1,
    CFG_LETTER_GAP  = 2'd2,
    CFG_WORD_GAP    = 2'd3
  } tsmd_cfg_e;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_LOOKUP = 1'b1
  } tsmd_kind_e;

  // One command from the front to the back: a table write or a lookup.
  typedef struct packed {
    tsmd_kind_e        kind;
    logic [CODE_W-1:0] code;
    logic [7:0]        chr;
    logic              ovf;
    logic              word;
    logic              eom;
  } tsmd_cmd_t;

  // Status from the back to the front.
  typedef struct packed {
    logic clearing;
  } tsmd_status_t;

  // Run length against a register value, both zero extended.
  function automatic logic run_eq(logic [RUN_WIDTH-1:0] run, logic [CFG_WIDTH-1:0] val);
    run_eq = (CMP_W'(run) == CMP_W'(val));
  endfunction

endpackage

// ----- rtl/tsmd_if.sv -----
// Channel interfaces of the Morse decoder: input items, results and configuration.
interface tsmd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       signal_bit;
  logic [8:0] entry_index;
  logic [7:0] entry_char;

  modport source (output valid, output opcode, output signal_bit, output entry_index,
                  output entry_char, input ready);
  modport sink   (input valid, input opcode, input signal_bit, input entry_index,
                  input entry_char, output ready);
endinterface

interface tsmd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_item;
  logic       end_of_message;

  modport source (output valid, output out_char, output last_of_item,
                  output end_of_message, input ready);
  modport sink   (input valid, input out_char, input last_of_item,
                  input end_of_message, output ready);
endinterface

interface tsmd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/timed_signal_morse_decoder.sv -----
// Top level of the timed on/off signal to Morse character decoder.
//
//   channel   modport  carries                                        direction
//   item_i    sink     opcode, signal_bit, entry_index, entry_char    in
//   cfg_i     sink     index (register number), data (16 bits)        in
//   result_o  source   out_char, last_of_item, end_of_message         out
//
// The decoder takes one request per cycle on item_i unless the clearing pass or a
// full queue holds item_i.ready low. The back reads the code table once per lookup,
// so a letter yields one result and a word gap two (the character, then the space).
// After reset the back runs a clearing pass over the 512-entry code table, one
// entry per cycle; item_i.ready stays low until the pass is done, while cfg_i
// writes are taken at all times.
// A four-entry command queue sits between front and back, so a stalled result_o
// only blocks item_i once the queue has filled up.
module timed_signal_morse_decoder import tsmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsmd_in_if.sink     item_i,
  tsmd_cfg_if.sink    cfg_i,
  tsmd_out_if.source  result_o
);

  tsmd_status_t status;
  tsmd_cmd_t    push_cmd;
  tsmd_cmd_t    head_cmd;
  logic         push;
  logic         pop;
  logic         fifo_full;
  logic         fifo_empty;

  // Front: measures runs and assembles the pending code, emits commands.
  tsmd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_i       (cfg_i),
    .status_i    (status),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Queue decoupling the two halves.
  tsmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .empty_o (fifo_empty)
  );

  // Back: owns the code table and the output register.
  tsmd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head_cmd),
    .empty_i  (fifo_empty),
    .pop_o    (pop),
    .status_o (status),
    .result_o (result_o)
  );

endmodule

// ----- rtl/tsmd_front.sv -----
// Front part: configuration registers, run measurement and symbol assembly.
module tsmd_front import tsmd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  tsmd_in_if.sink       item_i,
  tsmd_cfg_if.sink      cfg_i,
  input  tsmd_status_t  status_i,
  input  logic          fifo_full_i,
  output logic          push_o,
  output tsmd_cmd_t     cmd_o
);

  logic [CFG_WIDTH-1:0]  dash_len_q, sym_gap_q, let_gap_q, word_gap_q;
  logic                  prev_q, prev_d;
  logic                  started_q, started_d;
  logic [RUN_WIDTH-1:0]  run_q, run_d;
  logic [RUN_WIDTH-1:0]  high_q, high_d;
  logic [CODE_W-1:0]     code_q, code_d;
  logic [MARK_CNT_W-1:0] marks_q, marks_d;
  logic                  ovf_q, ovf_d;

  logic                  accept;
  logic [RUN_WIDTH-1:0]  mark_run;
  logic [CODE_W-1:0]     app_code;
  logic [MARK_CNT_W-1:0] app_marks;
  logic                  app_ovf;

  assign item_i.ready = !status_i.clearing && !fifo_full_i;
  assign cfg_i.ready  = 1'b1;
  assign accept       = item_i.valid && item_i.ready;

  // The mark to append uses the closing high run on an end item, else the stored one.
  assign mark_run = (item_i.opcode == OP_END && started_q && prev_q) ? run_q : high_q;

  always_comb begin
    app_code  = code_q;
    app_marks = marks_q;
    app_ovf   = ovf_q;
    if (ovf_q || marks_q >= MARK_CNT_W'(MAX_MARKS)) begin
      app_ovf = 1'b1;
    end else begin
      app_code  = {code_q[CODE_W-2:0], run_eq(mark_run, dash_len_q)};
      app_marks = marks_q + 1'b1;
    end
  end

  always_comb begin
    prev_d    = prev_q;
    started_d = started_q;
    run_d     = run_q;
    high_d    = high_q;
    code_d    = code_q;
    marks_d   = marks_q;
    ovf_d     = ovf_q;
    push_o    = 1'b0;
    cmd_o     = '{kind: CMD_LOOKUP, code: app_code, chr: item_i.entry_char,
                  ovf: app_ovf, word: 1'b0, eom: 1'b0};
    if (accept) begin
      case (item_i.opcode)
        OP_LOAD: begin
          push_o     = 1'b1;
          cmd_o.kind = CMD_LOAD;
          cmd_o.code = CODE_W'(item_i.entry_index);
        end
        OP_END: begin
          push_o    = 1'b1;
          cmd_o.eom = 1'b1;
          prev_d    = 1'b0;
          started_d = 1'b0;
          run_d     = '0;
          high_d    = '0;
          code_d    = CODE_W'(1);
          marks_d   = '0;
          ovf_d     = 1'b0;
        end
        OP_SIGNAL: begin
          if (!started_q) begin
            started_d = 1'b1;
            prev_d    = item_i.signal_bit;
            run_d     = RUN_WIDTH'(1);
          end else if (item_i.signal_bit == prev_q) begin
            if (run_q != '1) begin
              run_d = run_q + 1'b1;
            end
          end else begin
            if (prev_q) begin
              high_d = run_q;
            end else if (run_eq(run_q, let_gap_q) || run_eq(run_q, word_gap_q)) begin
              push_o     = 1'b1;
              cmd_o.word = !run_eq(run_q, let_gap_q);
              code_d     = CODE_W'(1);
              marks_d    = '0;
              ovf_d      = 1'b0;
              high_d     = '0;
            end else if (run_eq(run_q, sym_gap_q)) begin
              code_d  = app_code;
              marks_d = app_marks;
              ovf_d   = app_ovf;
              high_d  = '0;
            end
            prev_d = item_i.signal_bit;
            run_d  = RUN_WIDTH'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dash_len_q <= CFG_WIDTH'(3);
      sym_gap_q  <= CFG_WIDTH'(1);
      let_gap_q  <= CFG_WIDTH'(3);
      word_gap_q <= CFG_WIDTH'(7);
      prev_q     <= 1'b0;
      started_q  <= 1'b0;
      run_q      <= '0;
      high_q     <= '0;
      code_q     <= CODE_W'(1);
      marks_q    <= '0;
      ovf_q      <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_DASH_LENGTH: dash_len_q <= cfg_i.data;
          CFG_SYMBOL_GAP:  sym_gap_q  <= cfg_i.data;
          CFG_LETTER_GAP:  let_gap_q  <= cfg_i.data;
          CFG_WORD_GAP:    word_gap_q <= cfg_i.data;
          default: begin
          end
        endcase
      end
      prev_q    <= prev_d;
      started_q <= started_d;
      run_q     <= run_d;
      high_q    <= high_d;
      code_q    <= code_d;
      marks_q   <= marks_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

// ----- rtl/tsmd_fifo.sv -----
// Short command queue between the front and the back.
module tsmd_fifo import tsmd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tsmd_cmd_t cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output tsmd_cmd_t head_o,
  output logic      empty_o
);

  tsmd_cmd_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/tsmd_back.sv -----
// Back part: code table memory with its clearing pass, lookups and result output.
module tsmd_back import tsmd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tsmd_cmd_t     head_i,
  input  logic          empty_i,
  output logic          pop_o,
  output tsmd_status_t  status_o,
  tsmd_out_if.source    result_o
);

  logic [7:0]        table_q [TABLE_DEPTH];
  logic              clearing_q;
  logic [CODE_W-1:0] clr_cnt_q;

  logic              out_valid_q;
  logic              space_q;
  logic              word_q;
  logic              eom_q;
  logic              ovf_q;
  logic [7:0]        rdata_q;

  logic              taken;
  logic              final_beat;
  logic              out_free;
  logic              pop_lookup;

  assign status_o.clearing = clearing_q;

  assign taken      = out_valid_q && result_o.ready;
  assign final_beat = taken && (space_q || !word_q);
  assign out_free   = !out_valid_q || final_beat;
  assign pop_o      = !clearing_q && !empty_i && (head_i.kind == CMD_LOAD || out_free);
  assign pop_lookup = pop_o && head_i.kind == CMD_LOOKUP;

  assign result_o.valid          = out_valid_q;
  assign result_o.out_char       = space_q ? CH_SPACE : (ovf_q ? CH_NONE : rdata_q);
  assign result_o.last_of_item   = space_q || !word_q;
  assign result_o.end_of_message = !space_q && eom_q;

  // Single write port, single registered read port.
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      table_q[clr_cnt_q] <= CH_NONE;
    end else if (pop_o && head_i.kind == CMD_LOAD) begin
      table_q[head_i.code] <= head_i.chr;
    end
    if (pop_lookup) begin
      rdata_q <= table_q[head_i.code];
      word_q  <= head_i.word;
      eom_q   <= head_i.eom;
      ovf_q   <= head_i.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      space_q     <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == '1) begin
          clearing_q <= 1'b0;
        end
      end
      if (pop_lookup) begin
        out_valid_q <= 1'b1;
        space_q     <= 1'b0;
      end else if (final_beat) begin
        out_valid_q <= 1'b0;
        space_q     <= 1'b0;
      end else if (taken) begin
        space_q <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/tsmd_checker.sv -----
// Port-level checker for the Morse decoder and its bind to the top level.
module tsmd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       item_ready,
  input logic       cfg_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last,
  input logic       out_eom
);

  // The end item's character is always the last result of that item.
  a_eom_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (!out_eom || out_last))
    else $error("end_of_message without last_of_item");

  // A character closed by a word gap is followed at once by the space.
  a_word_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && out_char == 8'd32 && out_last && !out_eom))
    else $error("word gap space missing after its character");

  // The table clearing pass keeps the input closed right after reset.
  a_clear_blocks: assert property (@(posedge clk_i)
    !rst_ni |=> !item_ready)
    else $error("input ready during table clearing");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_char) && $stable(out_last) && $stable(out_eom)))
    else $error("stalled result changed");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind timed_signal_morse_decoder tsmd_checker u_tsmd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .item_ready (item_i.ready),
  .cfg_ready  (cfg_i.ready),
  .out_valid  (result_o.valid),
  .out_ready  (result_o.ready),
  .out_char   (result_o.out_char),
  .out_last   (result_o.last_of_item),
  .out_eom    (result_o.end_of_message)
);
